FILE: src/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Shared widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package c8ic_pkg;

   localparam int ADDR_W     = 12;
   localparam int CMD_W      = 3;
   localparam int ROW_W      = 5;
   localparam int KEY_W      = 16;
   localparam int PIX_W      = 64;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_STEP  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROW   = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WAIT_KEY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_STACK    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED   = 1'd1;

   localparam logic [ADDR_W-1:0] START_RESET = 12'd512;
   localparam logic [15:0]       SEED_RESET  = 16'd44257;
   localparam logic [15:0]       LFSR_TAPS   = 16'hB400;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_MEM,
      ST_RD_ROW,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_READ_X,
      ST_READ_Y,
      ST_EXEC,
      ST_RET,
      ST_WR_FLAG,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_BCD,
      ST_SAVE_RD,
      ST_SAVE_WR,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_DONE
   } state_type;

endpackage

FILE: src/c8ic_if.sv
// ----------------------------------------------------------------------------
// CHIP-8 core channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface c8ic_req_if import c8ic_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] address;
   logic [7:0]        write_data;
   logic [KEY_W-1:0]  key_states;
   logic [ROW_W-1:0]  row_select;

   modport source (output valid, command, address, write_data, key_states, row_select,
                   input ready);
   modport sink   (input valid, command, address, write_data, key_states, row_select,
                   output ready);
endinterface

interface c8ic_rsp_if import c8ic_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   program_counter;
   logic [7:0]          read_data;
   logic [PIX_W-1:0]    display_row;
   logic                beep;
   logic                halted;

   modport source (output valid, status, program_counter, read_data, display_row, beep,
                   halted, input ready);
   modport sink   (input valid, status, program_counter, read_data, display_row, beep,
                   halted, output ready);
endinterface

FILE: src/c8ic_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module c8ic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: src/chip8_instruction_core_top.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Tick, write and unused commands go straight to the response, reads through a
// read state. A step fetches the opcode, reads Vx and Vy, then executes; a draw
// reads and rewrites each sprite row, then VF; save and load move one register at
// a time; BCD stores three digits. One request at a time: ready only while idle.
// Synchronous reset: registers zero, pc 512, LFSR seed 44257, screen blank.
// ----------------------------------------------------------------------------
module chip8_instruction_core_top import c8ic_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   c8ic_req_if.sink              req_chan,
   c8ic_rsp_if.source            rsp_chan,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);

   // Sequencer and request registers.
   state_type state_ff, state_in, exec_next;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        wdata_ff, wdata_in;
   logic [KEY_W-1:0]  keys_ff, keys_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Instruction registers.
   logic [7:0] op_hi_ff, op_hi_in, op_lo_ff, op_lo_in;
   logic [7:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       hit_ff, hit_in, flag_ff, flag_in;

   // Result holding registers.
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [7:0]          rd_ff, rd_in;
   logic [PIX_W-1:0]    disp_ff, disp_in;
   logic                beep_ff, beep_in;

   // Architectural state.
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [15:0]       idx_ff, idx_in;
   logic [SCW-1:0]    sp_ff, sp_in;
   logic [7:0]        delay_ff, delay_in, sound_ff, sound_in;
   logic [15:0]       lfsr_ff, lfsr_in;
   logic              halt_ff, halt_in;
   logic [15:0]       reg_valid_ff, reg_valid_in;
   logic [31:0]       fb_valid_ff, fb_valid_in;
   logic [3:0]        reg_raddr_q;
   logic [ROW_W-1:0]  fb_raddr_q;

   // Response output registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_pc_ff, rsp_pc_in;
   logic [7:0]          rsp_rd_ff, rsp_rd_in;
   logic [PIX_W-1:0]    rsp_disp_ff, rsp_disp_in;
   logic                rsp_beep_ff, rsp_beep_in;
   logic                rsp_halt_ff, rsp_halt_in;

   // Memory ports.
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;
   logic              reg_we;
   logic [3:0]        reg_waddr, reg_raddr;
   logic [7:0]        reg_wdata, reg_rdata;
   logic              fb_we;
   logic [ROW_W-1:0]  fb_waddr, fb_raddr;
   logic [PIX_W-1:0]  fb_wdata, fb_rdata;
   logic              stk_we;
   logic [SIW-1:0]    stk_waddr, stk_raddr;
   logic [ADDR_W-1:0] stk_wdata, stk_rdata;

   // Decode helpers.
   logic              accept, rsp_free;
   logic [3:0]        op_x, op_y, op_n, op_grp;
   logic [ADDR_W-1:0] nnn;
   logic [7:0]        reg_rd;
   logic [PIX_W-1:0]  fb_rd;
   logic [8:0]        sum9;
   logic [15:0]       lfsr_step;
   logic [1:0]        bcd_h;
   logic [7:0]        bcd_rem;
   logic [14:0]       bcd_tprod;
   logic [3:0]        bcd_t;
   logic [7:0]        bcd_digit;
   logic [PIX_W-1:0]  sprite_line, sprite_mask;
   logic [SCW-1:0]    sp_dec;
   logic              clear_fb;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign op_grp = op_hi_ff[7:4];
   assign op_x   = op_hi_ff[3:0];
   assign op_y   = op_lo_ff[7:4];
   assign op_n   = op_lo_ff[3:0];
   assign nnn    = {op_hi_ff[3:0], op_lo_ff};
   assign sp_dec = sp_ff - SCW'(1);

   // Entries never written read as their reset value of zero.
   assign reg_rd = reg_valid_ff[reg_raddr_q] ? reg_rdata : 8'd0;
   assign fb_rd  = fb_valid_ff[fb_raddr_q] ? fb_rdata : '0;

   assign sum9      = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign lfsr_step = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);

   // BCD digits: hundreds by compare, tens by reciprocal multiply.
   always_comb begin
      bcd_h     = (vx_ff >= 8'd200) ? 2'd2 : ((vx_ff >= 8'd100) ? 2'd1 : 2'd0);
      bcd_rem   = vx_ff - 8'(bcd_h * 8'd100);
      bcd_tprod = 15'(bcd_rem[6:0]) * 15'd205;
      bcd_t     = bcd_tprod[14:11];
      unique case (cnt_ff)
         4'd0:    bcd_digit = {6'd0, bcd_h};
         4'd1:    bcd_digit = {4'd0, bcd_t};
         default: bcd_digit = bcd_rem - 8'(bcd_t * 8'd10);
      endcase
   end

   // Sprite byte placed at the x offset, wrapping around the row.
   assign sprite_line = {mem_rdata, 56'd0};
   assign sprite_mask = (sprite_line >> vx_ff[5:0])
                      | (sprite_line << (7'd64 - {1'b0, vx_ff[5:0]}));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.command == CMD_STEP && !halt_ff) begin
                  state_in = ST_FETCH_HI;
               end else if (req_chan.command == CMD_READ) begin
                  state_in = ST_RD_MEM;
               end else if (req_chan.command == CMD_ROW) begin
                  state_in = ST_RD_ROW;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD_MEM:   state_in = ST_DONE;
         ST_RD_ROW:   state_in = ST_DONE;
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_READ_X;
         ST_READ_X:   state_in = ST_READ_Y;
         ST_READ_Y:   state_in = ST_EXEC;
         ST_EXEC:     state_in = exec_next;
         ST_RET:      state_in = ST_DONE;
         ST_WR_FLAG:  state_in = ST_DONE;
         ST_DRAW_RD:  state_in = (cnt_ff == op_n) ? ST_WR_FLAG : ST_DRAW_WR;
         ST_DRAW_WR:  state_in = ST_DRAW_RD;
         ST_BCD:      state_in = (cnt_ff == 4'd2) ? ST_DONE : ST_BCD;
         ST_SAVE_RD:  state_in = ST_SAVE_WR;
         ST_SAVE_WR:  state_in = (cnt_ff == op_x) ? ST_DONE : ST_SAVE_RD;
         ST_LOAD_RD:  state_in = ST_LOAD_WR;
         ST_LOAD_WR:  state_in = (cnt_ff == op_x) ? ST_DONE : ST_LOAD_RD;
         ST_DONE:     state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      addr_in   = addr_ff;
      wdata_in  = wdata_ff;
      keys_in   = keys_ff;
      row_in    = row_ff;
      op_hi_in  = op_hi_ff;
      op_lo_in  = op_lo_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      disp_in   = disp_ff;
      beep_in   = beep_ff;
      pc_in     = pc_ff;
      idx_in    = idx_ff;
      sp_in     = sp_ff;
      delay_in  = delay_ff;
      sound_in  = sound_ff;
      lfsr_in   = lfsr_ff;
      halt_in   = halt_ff;
      exec_next = ST_DONE;
      clear_fb  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = wdata_ff;
      mem_raddr = pc_ff;
      reg_we    = 1'b0;
      reg_waddr = op_x;
      reg_wdata = 8'd0;
      reg_raddr = op_x;
      fb_we     = 1'b0;
      fb_waddr  = fb_raddr_q;
      fb_wdata  = '0;
      fb_raddr  = row_ff;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SIW-1:0];
      stk_wdata = pc_ff;
      stk_raddr = sp_dec[SIW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in   = req_chan.address;
               wdata_in  = req_chan.write_data;
               keys_in   = req_chan.key_states;
               row_in    = req_chan.row_select;
               status_in = STATUS_OK;
               rd_in     = 8'd0;
               disp_in   = '0;
               beep_in   = 1'b0;
               mem_raddr = (req_chan.command == CMD_READ) ? req_chan.address : pc_ff;
               fb_raddr  = req_chan.row_select;
               if (req_chan.command == CMD_TICK) begin
                  if (delay_ff != 8'd0) begin
                     delay_in = delay_ff - 8'd1;
                  end
                  if (sound_ff != 8'd0) begin
                     sound_in = sound_ff - 8'd1;
                     beep_in  = (sound_ff == 8'd2);
                  end
               end
               if (req_chan.command == CMD_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = req_chan.address;
                  mem_wdata = req_chan.write_data;
               end
            end
         end
         ST_RD_MEM: rd_in   = mem_rdata;
         ST_RD_ROW: disp_in = fb_rd;
         ST_FETCH_HI: begin
            op_hi_in  = mem_rdata;
            mem_raddr = pc_ff + 12'd1;
         end
         ST_FETCH_LO: begin
            op_lo_in  = mem_rdata;
            reg_raddr = op_x;
         end
         ST_READ_X: begin
            vx_in     = reg_rd;
            reg_raddr = op_y;
         end
         ST_READ_Y: begin
            vy_in     = reg_rd;
            reg_raddr = 4'd0;
         end
         ST_EXEC: begin
            pc_in  = pc_ff + 12'd2;
            cnt_in = 4'd0;
            hit_in = 1'b0;
            unique case (op_grp)
               4'h0: begin
                  if (op_lo_ff == 8'hE0) begin
                     clear_fb = 1'b1;
                  end else if (op_lo_ff == 8'hEE) begin
                     if (sp_ff == '0) begin
                        status_in = STATUS_STACK;
                     end else begin
                        sp_in     = sp_dec;
                        exec_next = ST_RET;
                     end
                  end else begin
                     status_in = STATUS_BAD_OP;
                  end
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  if (sp_ff >= SCW'(STACK_DEPTH)) begin
                     status_in = STATUS_STACK;
                  end else begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SCW'(1);
                     pc_in  = nnn;
                  end
               end
               4'h3: if (vx_ff == op_lo_ff) pc_in = pc_ff + 12'd4;
               4'h4: if (vx_ff != op_lo_ff) pc_in = pc_ff + 12'd4;
               4'h5: if (vx_ff == vy_ff) pc_in = pc_ff + 12'd4;
               4'h6: begin
                  reg_we    = 1'b1;
                  reg_wdata = op_lo_ff;
               end
               4'h7: begin
                  reg_we    = 1'b1;
                  reg_wdata = vx_ff + op_lo_ff;
               end
               4'h8: begin
                  reg_we = 1'b1;
                  unique case (op_n)
                     4'h0: reg_wdata = vy_ff;
                     4'h1: reg_wdata = vx_ff | vy_ff;
                     4'h2: reg_wdata = vx_ff & vy_ff;
                     4'h3: reg_wdata = vx_ff ^ vy_ff;
                     4'h4: begin
                        reg_wdata = sum9[7:0];
                        flag_in   = sum9[8];
                        exec_next = ST_WR_FLAG;
                     end
                     4'h5: begin
                        reg_wdata = vx_ff - vy_ff;
                        flag_in   = (vx_ff > vy_ff);
                        exec_next = ST_WR_FLAG;
                     end
                     4'h6: begin
                        reg_wdata = {1'b0, vx_ff[7:1]};
                        flag_in   = vx_ff[0];
                        exec_next = ST_WR_FLAG;
                     end
                     4'h7: begin
                        reg_wdata = vy_ff - vx_ff;
                        flag_in   = (vy_ff > vx_ff);
                        exec_next = ST_WR_FLAG;
                     end
                     4'hE: begin
                        reg_wdata = {vx_ff[6:0], 1'b0};
                        flag_in   = vx_ff[7];
                        exec_next = ST_WR_FLAG;
                     end
                     default: begin
                        reg_we    = 1'b0;
                        status_in = STATUS_BAD_OP;
                     end
                  endcase
               end
               4'h9: if (vx_ff != vy_ff) pc_in = pc_ff + 12'd4;
               4'hA: idx_in = {4'd0, nnn};
               4'hB: pc_in = nnn + {4'd0, reg_rd};
               4'hC: begin
                  lfsr_in   = lfsr_step;
                  reg_we    = 1'b1;
                  reg_wdata = lfsr_step[7:0] & op_lo_ff;
               end
               4'hD: exec_next = ST_DRAW_RD;
               4'hE: begin
                  if (op_lo_ff == 8'h9E) begin
                     if (keys_ff[vx_ff[3:0]]) pc_in = pc_ff + 12'd4;
                  end else if (op_lo_ff == 8'hA1) begin
                     if (!keys_ff[vx_ff[3:0]]) pc_in = pc_ff + 12'd4;
                  end else begin
                     status_in = STATUS_BAD_OP;
                  end
               end
               default: begin
                  unique case (op_lo_ff)
                     8'h07: begin
                        reg_we    = 1'b1;
                        reg_wdata = delay_ff;
                     end
                     8'h0A: status_in = STATUS_WAIT_KEY;
                     8'h15: delay_in  = vx_ff;
                     8'h18: sound_in  = vx_ff;
                     8'h1E: idx_in    = idx_ff + {8'd0, vx_ff};
                     8'h29: idx_in    = 16'({8'd0, vx_ff} * 16'd5);
                     8'h33: exec_next = ST_BCD;
                     8'h55: exec_next = ST_SAVE_RD;
                     8'h65: exec_next = ST_LOAD_RD;
                     default: status_in = STATUS_BAD_OP;
                  endcase
               end
            endcase
            // A fault leaves the program counter on the faulting opcode.
            if (status_in != STATUS_OK) begin
               pc_in     = pc_ff;
               halt_in   = 1'b1;
               exec_next = ST_DONE;
            end
         end
         ST_RET: pc_in = stk_rdata + 12'd2;
         ST_WR_FLAG: begin
            reg_we    = 1'b1;
            reg_waddr = 4'hF;
            reg_wdata = {7'd0, flag_ff};
         end
         ST_DRAW_RD: begin
            mem_raddr = idx_ff[ADDR_W-1:0] + {8'd0, cnt_ff};
            fb_raddr  = vy_ff[ROW_W-1:0] + {1'b0, cnt_ff};
            flag_in   = hit_ff;
         end
         ST_DRAW_WR: begin
            hit_in   = hit_ff | (|(fb_rd & sprite_mask));
            fb_we    = 1'b1;
            fb_waddr = fb_raddr_q;
            fb_wdata = fb_rd ^ sprite_mask;
            cnt_in   = cnt_ff + 4'd1;
         end
         ST_BCD: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0] + {8'd0, cnt_ff};
            mem_wdata = bcd_digit;
            cnt_in    = cnt_ff + 4'd1;
         end
         ST_SAVE_RD: reg_raddr = cnt_ff;
         ST_SAVE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0] + {8'd0, cnt_ff};
            mem_wdata = reg_rd;
            cnt_in    = cnt_ff + 4'd1;
         end
         ST_LOAD_RD: mem_raddr = idx_ff[ADDR_W-1:0] + {8'd0, cnt_ff};
         ST_LOAD_WR: begin
            reg_we    = 1'b1;
            reg_waddr = cnt_ff;
            reg_wdata = mem_rdata;
            cnt_in    = cnt_ff + 4'd1;
         end
         ST_DONE: ;
         default: ;
      endcase

      // Configuration writes must arrive only while the core is idle; the block does not enforce this.
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_ADDRESS: pc_in   = csr_data[ADDR_W-1:0];
            CSR_RANDOM_SEED:   lfsr_in = csr_data;
            default: ;
         endcase
      end
   end

   // Valid bits for the register file and the frame buffer rows.
   always_comb begin
      reg_valid_in = reg_valid_ff;
      fb_valid_in  = clear_fb ? 32'd0 : fb_valid_ff;
      if (reg_we) begin
         reg_valid_in[reg_waddr] = 1'b1;
      end
      if (fb_we) begin
         fb_valid_in[fb_waddr] = 1'b1;
      end
   end

   // Response register loads when the result slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_beep_in   = rsp_beep_ff;
      rsp_halt_in   = rsp_halt_ff;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_pc_in     = pc_ff;
         rsp_rd_in     = rd_ff;
         rsp_disp_in   = disp_ff;
         rsp_beep_in   = beep_ff;
         rsp_halt_in   = halt_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.program_counter = rsp_pc_ff;
   assign rsp_chan.read_data       = rsp_rd_ff;
   assign rsp_chan.display_row     = rsp_disp_ff;
   assign rsp_chan.beep            = rsp_beep_ff;
   assign rsp_chan.halted          = rsp_halt_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= START_RESET;
         idx_ff       <= 16'd0;
         sp_ff        <= '0;
         delay_ff     <= 8'd0;
         sound_ff     <= 8'd0;
         lfsr_ff      <= SEED_RESET;
         halt_ff      <= 1'b0;
         reg_valid_ff <= 16'd0;
         fb_valid_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         sp_ff        <= sp_in;
         delay_ff     <= delay_in;
         sound_ff     <= sound_in;
         lfsr_ff      <= lfsr_in;
         halt_ff      <= halt_in;
         reg_valid_ff <= reg_valid_in;
         fb_valid_ff  <= fb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      wdata_ff      <= wdata_in;
      keys_ff       <= keys_in;
      row_ff        <= row_in;
      op_hi_ff      <= op_hi_in;
      op_lo_ff      <= op_lo_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      cnt_ff        <= cnt_in;
      hit_ff        <= hit_in;
      flag_ff       <= flag_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      disp_ff       <= disp_in;
      beep_ff       <= beep_in;
      reg_raddr_q   <= reg_raddr;
      fb_raddr_q    <= fb_raddr;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_beep_ff   <= rsp_beep_in;
      rsp_halt_ff   <= rsp_halt_in;
   end

   // Main memory, 4 KiB.
   c8ic_ram #(.WIDTH(8), .DEPTH(4096)) u_main_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // General registers V0 to VF.
   c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_reg_file (
      .clock (clock),
      .we    (reg_we),
      .waddr (reg_waddr),
      .wdata (reg_wdata),
      .raddr (reg_raddr),
      .rdata (reg_rdata)
   );

   // Frame buffer, one row per entry.
   c8ic_ram #(.WIDTH(PIX_W), .DEPTH(32)) u_frame_buf (
      .clock (clock),
      .we    (fb_we),
      .waddr (fb_waddr),
      .wdata (fb_wdata),
      .raddr (fb_raddr),
      .rdata (fb_rdata)
   );

   // Return address stack.
   c8ic_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_ret_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

endmodule
